// ----- src/u16u8_pkg.sv -----
package u16u8_pkg;

	typedef enum logic [2:0] {
		MODE_DETECT,
		MODE_UTF16,
		MODE_PASS,
		MODE_PDFDOC,
		MODE_DROP
	} mode_t;

	localparam logic [1:0] KIND_UTF8 = 2'd0;
	localparam logic [1:0] KIND_PASS = 2'd1;
	localparam logic [1:0] KIND_RAW  = 2'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_HIGH = 2'd1;
	localparam logic [1:0] ERR_LOW  = 2'd2;

	localparam logic [7:0] BYTE_FE = 8'hFE;
	localparam logic [7:0] BYTE_FF = 8'hFF;
	localparam logic [7:0] BYTE_EF = 8'hEF;
	localparam logic [7:0] BYTE_BB = 8'hBB;
	localparam logic [7:0] BYTE_BF = 8'hBF;

	localparam logic [15:0] HI_SUR_FIRST = 16'hD800;
	localparam logic [15:0] HI_SUR_LAST  = 16'hDBFF;
	localparam logic [15:0] LO_SUR_FIRST = 16'hDC00;
	localparam logic [15:0] LO_SUR_LAST  = 16'hDFFF;
	localparam logic [20:0] CP_SUPP_BASE = 21'h10000;

	localparam int MAX_RES = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic [1:0] byte_kind;
		logic [1:0] error_code;
		logic       out_last;
	} out_beat_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] hold0;
		logic [7:0] hold1;
		logic [1:0] hold_count;
		logic [7:0] pend_hi;
		logic       phase;
		logic [9:0] hs_bits;
		logic       sur_pend;
	} state_t;

	localparam state_t ST_IDLE = '{mode: MODE_DETECT, default: '0};

endpackage

// ----- src/utf16be_to_utf8_transcoder.sv -----
// Converts the bytes of one string, last byte marked, into result beats of one
// byte each. A leading FE FF selects UTF-16BE to UTF-8 conversion, EF BB BF
// selects pass-through with the mark removed, and any other start passes the
// bytes out raw, tagged for PDFDocEncoding mapping downstream. Each accepted
// byte is decoded from the input register into a result buffer of up to four
// beats, which drains one beat per cycle while out_stall is low; the next byte
// waits in the input register until the final beat of the buffer leaves. The
// last byte of a string always yields at least one beat with out_last set; an
// unpaired surrogate yields an error beat and the rest of that string is dropped.
module utf16be_to_utf8_transcoder import u16u8_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_beat,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_beat
);

	logic                     vld_s1;
	in_beat_t                 beat_s1;
	state_t                   st_q;
	out_beat_t [MAX_RES-1:0]  res_q;
	logic [2:0]               cnt_q;

	out_beat_t [MAX_RES-1:0]  dec_res;
	logic [2:0]               dec_num;
	state_t                   dec_nxt;

	logic pop;
	logic load;
	logic take;

	u16u8_decode u_decode (
		.st   (st_q),
		.beat (beat_s1),
		.res  (dec_res),
		.num  (dec_num),
		.nxt  (dec_nxt)
	);

	assign out_valid = (cnt_q != 3'd0);
	assign out_beat  = res_q[0];
	assign pop       = out_valid && !out_stall;
	// decode once the buffer is empty or its final beat leaves this cycle
	assign load      = vld_s1 && (cnt_q == 3'd0 || (cnt_q == 3'd1 && pop));
	assign in_stall  = vld_s1 && !load;
	assign take      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			cnt_q  <= 3'd0;
			st_q   <= ST_IDLE;
		end else begin
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (load) begin
				vld_s1 <= 1'b0;
			end
			if (load) begin
				cnt_q <= dec_num;
				st_q  <= dec_nxt;
			end else if (pop) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			beat_s1 <= in_beat;
		end
		if (load) begin
			res_q <= dec_res;
		end else if (pop) begin
			// advance the next beat to the head
			res_q <= {out_beat_t'('0), res_q[MAX_RES-1:1]};
		end
	end

endmodule

// ----- src/u16u8_decode.sv -----
module u16u8_decode import u16u8_pkg::*; (
	input  state_t                   st,
	input  in_beat_t                 beat,
	output out_beat_t [MAX_RES-1:0]  res,
	output logic [2:0]               num,
	output state_t                   nxt
);

	function automatic out_beat_t mk(input logic [7:0] b, input logic has,
			input logic [1:0] kind, input logic [1:0] err);
		out_beat_t r;
		r.out_byte   = b;
		r.has_byte   = has;
		r.byte_kind  = kind;
		r.error_code = err;
		r.out_last   = 1'b0;
		return r;
	endfunction

	logic [7:0]  b;
	logic        last;
	logic [15:0] unit;
	logic [20:0] cp;
	logic [1:0]  lkind;
	logic [1:0]  lidx;

	assign b    = beat.in_byte;
	assign last = beat.in_last;
	assign unit = {st.pend_hi, b};
	assign cp   = 21'({st.hs_bits, unit[9:0]}) + CP_SUPP_BASE;

	always_comb begin
		nxt   = st;
		res   = '0;
		num   = 3'd0;
		lkind = KIND_UTF8;
		lidx  = 2'd0;
		unique case (st.mode)
			MODE_DETECT: begin
				if (st.hold_count == 2'd0) begin
					if ((b == BYTE_FE || b == BYTE_EF) && !last) begin
						nxt.hold0      = b;
						nxt.hold_count = 2'd1;
					end else begin
						nxt.mode = MODE_PDFDOC;
						res[0]   = mk(b, 1'b1, KIND_RAW, ERR_NONE);
						num      = 3'd1;
					end
				end else if (st.hold_count == 2'd1) begin
					if (st.hold0 == BYTE_FE && b == BYTE_FF) begin
						nxt.mode       = MODE_UTF16;
						nxt.hold_count = 2'd0;
					end else if (st.hold0 == BYTE_EF && b == BYTE_BB && !last) begin
						nxt.hold1      = b;
						nxt.hold_count = 2'd2;
					end else begin
						// broken mark: flush the held byte as raw
						nxt.mode       = MODE_PDFDOC;
						nxt.hold_count = 2'd0;
						res[0]         = mk(st.hold0, 1'b1, KIND_RAW, ERR_NONE);
						res[1]         = mk(b, 1'b1, KIND_RAW, ERR_NONE);
						num            = 3'd2;
					end
				end else begin
					nxt.hold_count = 2'd0;
					if (b == BYTE_BF) begin
						nxt.mode = MODE_PASS;
					end else begin
						nxt.mode = MODE_PDFDOC;
						res[0]   = mk(st.hold0, 1'b1, KIND_RAW, ERR_NONE);
						res[1]   = mk(st.hold1, 1'b1, KIND_RAW, ERR_NONE);
						res[2]   = mk(b, 1'b1, KIND_RAW, ERR_NONE);
						num      = 3'd3;
					end
				end
			end
			MODE_UTF16: begin
				if (!st.phase) begin
					nxt.pend_hi = b;
					nxt.phase   = 1'b1;
					if (last && st.sur_pend) begin
						res[0]       = mk(8'h00, 1'b0, KIND_UTF8, ERR_HIGH);
						num          = 3'd1;
						nxt.mode     = MODE_DROP;
						nxt.sur_pend = 1'b0;
						nxt.phase    = 1'b0;
					end
				end else begin
					nxt.phase = 1'b0;
					if (st.sur_pend) begin
						if (unit < LO_SUR_FIRST || unit > LO_SUR_LAST) begin
							res[0]       = mk(8'h00, 1'b0, KIND_UTF8, ERR_HIGH);
							num          = 3'd1;
							nxt.mode     = MODE_DROP;
							nxt.sur_pend = 1'b0;
						end else begin
							nxt.sur_pend = 1'b0;
							res[0] = mk({5'b11110, cp[20:18]}, 1'b1, KIND_UTF8, ERR_NONE);
							res[1] = mk({2'b10, cp[17:12]}, 1'b1, KIND_UTF8, ERR_NONE);
							res[2] = mk({2'b10, cp[11:6]}, 1'b1, KIND_UTF8, ERR_NONE);
							res[3] = mk({2'b10, cp[5:0]}, 1'b1, KIND_UTF8, ERR_NONE);
							num    = 3'd4;
						end
					end else if (unit >= HI_SUR_FIRST && unit <= HI_SUR_LAST) begin
						nxt.hs_bits  = unit[9:0];
						nxt.sur_pend = 1'b1;
						if (last) begin
							res[0]       = mk(8'h00, 1'b0, KIND_UTF8, ERR_HIGH);
							num          = 3'd1;
							nxt.mode     = MODE_DROP;
							nxt.sur_pend = 1'b0;
						end
					end else if (unit >= LO_SUR_FIRST && unit <= LO_SUR_LAST) begin
						res[0]   = mk(8'h00, 1'b0, KIND_UTF8, ERR_LOW);
						num      = 3'd1;
						nxt.mode = MODE_DROP;
					end else if (unit[15:7] == 9'd0) begin
						res[0] = mk(unit[7:0], 1'b1, KIND_UTF8, ERR_NONE);
						num    = 3'd1;
					end else if (unit[15:11] == 5'd0) begin
						res[0] = mk({3'b110, unit[10:6]}, 1'b1, KIND_UTF8, ERR_NONE);
						res[1] = mk({2'b10, unit[5:0]}, 1'b1, KIND_UTF8, ERR_NONE);
						num    = 3'd2;
					end else begin
						res[0] = mk({4'hE, unit[15:12]}, 1'b1, KIND_UTF8, ERR_NONE);
						res[1] = mk({2'b10, unit[11:6]}, 1'b1, KIND_UTF8, ERR_NONE);
						res[2] = mk({2'b10, unit[5:0]}, 1'b1, KIND_UTF8, ERR_NONE);
						num    = 3'd3;
					end
				end
			end
			MODE_PASS: begin
				res[0] = mk(b, 1'b1, KIND_PASS, ERR_NONE);
				num    = 3'd1;
			end
			MODE_PDFDOC: begin
				res[0] = mk(b, 1'b1, KIND_RAW, ERR_NONE);
				num    = 3'd1;
			end
			default: begin
				// drop everything after an error
			end
		endcase

		if (last) begin
			unique case (nxt.mode) inside
				MODE_PASS:                lkind = KIND_PASS;
				MODE_PDFDOC, MODE_DETECT: lkind = KIND_RAW;
				default:                  lkind = KIND_UTF8;
			endcase
			if (num == 3'd0) begin
				res[0] = mk(8'h00, 1'b0, lkind, ERR_NONE);
				num    = 3'd1;
			end
			lidx = num[1:0] - 2'd1;
			res[lidx].out_last = 1'b1;
			nxt = ST_IDLE;
		end
	end

endmodule

// ----- dv/u16u8_stream_monitor.sv -----
module u16u8_stream_monitor import u16u8_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_beat_t  in_beat,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_beat_t out_beat,
	output int        mismatches,
	output int        outstanding
);

	mode_t       dec_mode;
	logic [7:0]  held [2];
	int unsigned held_n;
	logic [7:0]  hi_byte;
	logic        odd_byte;
	logic [9:0]  hs_bits;
	logic        hs_pend;

	out_beat_t   step_beats[$];
	out_beat_t   utf8_expected[$];
	out_beat_t   head;
	int          fail_cnt;

	task automatic clear_decoder();
		dec_mode = MODE_DETECT;
		held_n   = 0;
		odd_byte = 1'b0;
		hs_pend  = 1'b0;
	endtask

	task automatic emit(input logic [7:0] b, input logic has, input logic [1:0] kind,
			input logic [1:0] err);
		out_beat_t r;
		r.out_byte   = b;
		r.has_byte   = has;
		r.byte_kind  = kind;
		r.error_code = err;
		r.out_last   = 1'b0;
		step_beats = {step_beats, r};
	endtask

	// Emit the error marker and drop the rest of the string.
	task automatic flag_error(input logic [1:0] err);
		emit(8'h00, 1'b0, KIND_UTF8, err);
		dec_mode = MODE_DROP;
		hs_pend  = 1'b0;
		odd_byte = 1'b0;
	endtask

	task automatic pick_mode(input logic [7:0] b, input logic last);
		if (held_n == 0) begin
			if ((b == BYTE_FE || b == BYTE_EF) && !last) begin
				held[0] = b;
				held_n  = 1;
				return;
			end
			dec_mode = MODE_PDFDOC;
			emit(b, 1'b1, KIND_RAW, ERR_NONE);
			return;
		end
		if (held_n == 1) begin
			if (held[0] == BYTE_FE && b == BYTE_FF) begin
				dec_mode = MODE_UTF16;
				held_n   = 0;
				return;
			end
			if (held[0] == BYTE_EF && b == BYTE_BB && !last) begin
				held[1] = b;
				held_n  = 2;
				return;
			end
			// broken mark: flush what was held as raw bytes
			dec_mode = MODE_PDFDOC;
			held_n   = 0;
			emit(held[0], 1'b1, KIND_RAW, ERR_NONE);
			emit(b, 1'b1, KIND_RAW, ERR_NONE);
			return;
		end
		held_n = 0;
		if (b == BYTE_BF) begin
			dec_mode = MODE_PASS;
			return;
		end
		dec_mode = MODE_PDFDOC;
		emit(held[0], 1'b1, KIND_RAW, ERR_NONE);
		emit(held[1], 1'b1, KIND_RAW, ERR_NONE);
		emit(b, 1'b1, KIND_RAW, ERR_NONE);
	endtask

	task automatic decode_utf16(input logic [7:0] b, input logic last);
		logic [15:0] unit;
		logic [20:0] cp;
		if (!odd_byte) begin
			hi_byte  = b;
			odd_byte = 1'b1;
			if (last && hs_pend)
				flag_error(ERR_HIGH);
			return;
		end
		odd_byte = 1'b0;
		unit     = {hi_byte, b};
		if (hs_pend) begin
			if (unit < LO_SUR_FIRST || unit > LO_SUR_LAST) begin
				flag_error(ERR_HIGH);
				return;
			end
			hs_pend = 1'b0;
			cp = CP_SUPP_BASE + 21'({hs_bits, 10'd0}) + 21'(unit - LO_SUR_FIRST);
			emit({5'b11110, cp[20:18]}, 1'b1, KIND_UTF8, ERR_NONE);
			emit({2'b10, cp[17:12]}, 1'b1, KIND_UTF8, ERR_NONE);
			emit({2'b10, cp[11:6]}, 1'b1, KIND_UTF8, ERR_NONE);
			emit({2'b10, cp[5:0]}, 1'b1, KIND_UTF8, ERR_NONE);
			return;
		end
		if (unit >= HI_SUR_FIRST && unit <= HI_SUR_LAST) begin
			hs_bits = unit[9:0];
			hs_pend = 1'b1;
			if (last)
				flag_error(ERR_HIGH);
			return;
		end
		if (unit >= LO_SUR_FIRST && unit <= LO_SUR_LAST) begin
			flag_error(ERR_LOW);
			return;
		end
		if (unit <= 16'h007F) begin
			emit(unit[7:0], 1'b1, KIND_UTF8, ERR_NONE);
		end else if (unit <= 16'h07FF) begin
			emit({3'b110, unit[10:6]}, 1'b1, KIND_UTF8, ERR_NONE);
			emit({2'b10, unit[5:0]}, 1'b1, KIND_UTF8, ERR_NONE);
		end else begin
			emit({4'b1110, unit[15:12]}, 1'b1, KIND_UTF8, ERR_NONE);
			emit({2'b10, unit[11:6]}, 1'b1, KIND_UTF8, ERR_NONE);
			emit({2'b10, unit[5:0]}, 1'b1, KIND_UTF8, ERR_NONE);
		end
	endtask

	task automatic transcode_beat(input in_beat_t beat);
		logic [1:0] end_kind;
		step_beats.delete();
		case (dec_mode)
			MODE_DETECT: pick_mode(beat.in_byte, beat.in_last);
			MODE_UTF16:  decode_utf16(beat.in_byte, beat.in_last);
			MODE_PASS:   emit(beat.in_byte, 1'b1, KIND_PASS, ERR_NONE);
			MODE_PDFDOC: emit(beat.in_byte, 1'b1, KIND_RAW, ERR_NONE);
			default: ;
		endcase
		if (beat.in_last) begin
			if (step_beats.size() == 0) begin
				end_kind = (dec_mode == MODE_PASS) ? KIND_PASS :
					(dec_mode == MODE_PDFDOC || dec_mode == MODE_DETECT) ? KIND_RAW :
					KIND_UTF8;
				emit(8'h00, 1'b0, end_kind, ERR_NONE);
			end
			step_beats[step_beats.size() - 1].out_last = 1'b1;
			clear_decoder();
		end
		utf8_expected = {utf8_expected, step_beats};
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_decoder();
			utf8_expected.delete();
			fail_cnt = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// check the result side first: a beat taken now cannot answer this edge's input
			if (out_valid && !out_stall) begin
				if (utf8_expected.size() == 0) begin
					$error("unexpected beat: out_byte %h has_byte %b last %b",
						out_beat.out_byte, out_beat.has_byte, out_beat.out_last);
					fail_cnt++;
				end else begin
					head = utf8_expected.pop_front();
					if (out_beat.out_byte !== head.out_byte) begin
						$error("out_byte: expected %h, got %h", head.out_byte, out_beat.out_byte);
						fail_cnt++;
					end
					if (out_beat.has_byte !== head.has_byte) begin
						$error("has_byte: expected %b, got %b", head.has_byte, out_beat.has_byte);
						fail_cnt++;
					end
					if (out_beat.byte_kind !== head.byte_kind) begin
						$error("byte_kind: expected %0d, got %0d", head.byte_kind,
							out_beat.byte_kind);
						fail_cnt++;
					end
					if (out_beat.error_code !== head.error_code) begin
						$error("error_code: expected %0d, got %0d", head.error_code,
							out_beat.error_code);
						fail_cnt++;
					end
					if (out_beat.out_last !== head.out_last) begin
						$error("out_last: expected %b, got %b", head.out_last, out_beat.out_last);
						fail_cnt++;
					end
				end
			end
			if (in_valid && !in_stall)
				transcode_beat(in_beat);
			mismatches  <= fail_cnt;
			outstanding <= utf8_expected.size();
		end
	end

endmodule

// ----- dv/utf16be_to_utf8_transcoder_tb.sv -----
module utf16be_to_utf8_transcoder_tb;
	import u16u8_pkg::*;

	localparam int RANDOM_ITEMS = 250;
	localparam int CYCLE_LIMIT  = 400000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	in_beat_t  in_beat   = '0;
	logic      out_stall = 1'b0;
	logic      in_stall;
	logic      out_valid;
	out_beat_t out_beat;

	int        mismatches;
	int        outstanding;
	int        cycle_cnt = 0;
	int        items_sent = 0;
	bit        no_gaps = 1'b0;
	logic [7:0] text_q[$];

	bit        stall_on = 1'b0;
	int        stall_run = 0;

	utf16be_to_utf8_transcoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_beat (out_beat)
	);

	u16u8_stream_monitor i_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_beat    (in_beat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_beat   (out_beat),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic void push_unit(input logic [15:0] unit);
		text_q = {text_q, unit[15:8], unit[7:0]};
	endfunction

	// Send text_q as one string; hold each beat until it is taken.
	task automatic send_text();
		int gap;
		foreach (text_q[i]) begin
			gap = no_gaps ? 0 : draw_gap();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_beat  <= '{in_byte: text_q[i], in_last: (i == text_q.size() - 1)};
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
		end
		text_q.delete();
	endtask

	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_on = ($urandom_range(0, 2) == 0);
			if (!stall_on && $urandom_range(0, 9) == 0)
				stall_run = $urandom_range(30, 100);
			else
				stall_run = draw_gap() + 1;
		end
		stall_run--;
		out_stall <= stall_on;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int         kind;
		int         sel;
		logic [15:0] u;
		logic [7:0] b;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single byte, lone FE, short EF BB, empty pass-through body
		text_q = '{8'hFF};
		send_text();
		text_q = '{BYTE_FE};
		send_text();
		text_q = '{BYTE_EF, BYTE_BB};
		send_text();
		text_q = '{BYTE_EF, BYTE_BB, BYTE_BF};
		send_text();
		// unit 0, top of two and three byte ranges, top surrogate pair, odd trailing byte
		text_q = '{BYTE_FE, BYTE_FF, 8'h00, 8'h00, 8'h07, 8'hFF, 8'hFF, 8'hFF,
			8'hDB, 8'hFF, 8'hDF, 8'hFF, 8'h5A};
		send_text();
		// lone low surrogate, then dropped tail
		text_q = '{BYTE_FE, BYTE_FF, 8'hDC, 8'h00, 8'h41};
		send_text();
		// high surrogate still waiting when an odd last byte arrives
		text_q = '{BYTE_FE, BYTE_FF, 8'hD8, 8'h00, 8'h12};
		send_text();

		while (items_sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				text_q = '{BYTE_FE, BYTE_FF};
				repeat ($urandom_range(0, 5)) begin
					sel = $urandom_range(0, 99);
					if (sel < 25) begin
						push_unit(16'($urandom_range(0, 16'h007F)));
					end else if (sel < 40) begin
						push_unit(16'($urandom_range(16'h0080, 16'h07FF)));
					end else if (sel < 60) begin
						// skip over the surrogate range
						u = 16'($urandom_range(16'h0800, 16'hF7FF));
						if (u >= HI_SUR_FIRST)
							u = u + 16'h0800;
						push_unit(u);
					end else if (sel < 85) begin
						push_unit(HI_SUR_FIRST | 16'($urandom_range(0, 10'h3FF)));
						push_unit(LO_SUR_FIRST | 16'($urandom_range(0, 10'h3FF)));
					end else if (sel < 93) begin
						push_unit(HI_SUR_FIRST | 16'($urandom_range(0, 10'h3FF)));
					end else begin
						push_unit(LO_SUR_FIRST | 16'($urandom_range(0, 10'h3FF)));
					end
				end
				if ($urandom_range(0, 6) == 0)
					text_q = {text_q, 8'($urandom)};
			end else if (kind < 70) begin
				text_q = '{BYTE_EF, BYTE_BB, BYTE_BF};
				repeat ($urandom_range(0, 6))
					text_q = {text_q, 8'($urandom)};
			end else if (kind < 85) begin
				repeat ($urandom_range(1, 6))
					text_q = {text_q, 8'($urandom)};
			end else begin
				sel = $urandom_range(0, 4);
				b   = 8'($urandom_range(0, 254));
				case (sel)
					0: text_q = '{BYTE_FE, b};
					1: text_q = '{BYTE_EF, (b == BYTE_BB) ? BYTE_FF : b};
					2: text_q = '{BYTE_EF, BYTE_BB, (b == BYTE_BF) ? BYTE_FF : b};
					3: text_q = '{$urandom_range(0, 1) ? BYTE_FE : BYTE_EF};
					default: text_q = '{BYTE_EF, BYTE_BB};
				endcase
				if (sel < 3)
					repeat ($urandom_range(0, 3))
						text_q = {text_q, 8'($urandom)};
			end
			items_sent += text_q.size();
			no_gaps = ($urandom_range(0, 3) == 0);
			send_text();
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
